/* sv/mclsc_pkg.sv */
`timescale 1ns / 1ps

package mclsc_pkg;

	// Register lengths and the key width.
	localparam int unsigned X_W   = 19;
	localparam int unsigned Y_W   = 22;
	localparam int unsigned Z_W   = 23;
	localparam int unsigned KEY_W = 64;

	// Where each register's fill starts inside the key.
	localparam int unsigned X_KEY_LO = 0;
	localparam int unsigned Y_KEY_LO = 19;
	localparam int unsigned Z_KEY_LO = 41;

	// Clock bits that feed the majority vote.
	localparam int unsigned X_CLK = 8;
	localparam int unsigned Y_CLK = 10;
	localparam int unsigned Z_CLK = 10;

	// Feedback taps.
	localparam int unsigned X_TAP_A = 13;
	localparam int unsigned X_TAP_B = 16;
	localparam int unsigned X_TAP_C = 17;
	localparam int unsigned X_TAP_D = 18;
	localparam int unsigned Y_TAP_A = 20;
	localparam int unsigned Y_TAP_B = 21;
	localparam int unsigned Z_TAP_A = 7;
	localparam int unsigned Z_TAP_B = 20;
	localparam int unsigned Z_TAP_C = 21;
	localparam int unsigned Z_TAP_D = 22;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [Z_W-1:0] z;
	} lfsr_state_t;

endpackage

/* sv/mclsc_ifs.sv */
`timescale 1ns / 1ps

interface mclsc_text_if;
	logic valid;
	logic ready;
	logic text_bit;

	modport source (output valid, output text_bit, input ready);
	modport sink (input valid, input text_bit, output ready);
endinterface

interface mclsc_result_if;
	logic valid;
	logic ready;
	logic out_bit;
	logic keystream_bit;
	logic last_in_block;

	modport source (output valid, output out_bit, output keystream_bit, output last_in_block,
		input ready);
	modport sink (input valid, input out_bit, input keystream_bit, input last_in_block,
		output ready);
endinterface

interface mclsc_key_if;
	logic                           valid;
	logic                           ready;
	logic [mclsc_pkg::KEY_W-1:0]    cipher_key;

	modport source (output valid, output cipher_key, input ready);
	modport sink (input valid, input cipher_key, output ready);
endinterface

/* sv/mclsc_step.sv */
`timescale 1ns / 1ps

// One majority-clocked step of the three registers and the keystream bit
// taken from the stepped registers.
module mclsc_step (
	input  mclsc_pkg::lfsr_state_t cur,
	output mclsc_pkg::lfsr_state_t nxt,
	output logic                   ks
);

	logic cx, cy, cz, maj;
	logic fb_x, fb_y, fb_z;

	assign cx  = cur.x[mclsc_pkg::X_CLK];
	assign cy  = cur.y[mclsc_pkg::Y_CLK];
	assign cz  = cur.z[mclsc_pkg::Z_CLK];
	assign maj = (cx & cy) | (cx & cz) | (cy & cz);

	assign fb_x = cur.x[mclsc_pkg::X_TAP_A] ^ cur.x[mclsc_pkg::X_TAP_B]
		^ cur.x[mclsc_pkg::X_TAP_C] ^ cur.x[mclsc_pkg::X_TAP_D];
	assign fb_y = cur.y[mclsc_pkg::Y_TAP_A] ^ cur.y[mclsc_pkg::Y_TAP_B];
	assign fb_z = cur.z[mclsc_pkg::Z_TAP_A] ^ cur.z[mclsc_pkg::Z_TAP_B]
		^ cur.z[mclsc_pkg::Z_TAP_C] ^ cur.z[mclsc_pkg::Z_TAP_D];

	// A register shifts only when its clock bit agrees with the majority.
	always_comb begin
		nxt = cur;
		if (cx == maj) begin
			nxt.x = {cur.x[mclsc_pkg::X_W-2:0], fb_x};
		end
		if (cy == maj) begin
			nxt.y = {cur.y[mclsc_pkg::Y_W-2:0], fb_y};
		end
		if (cz == maj) begin
			nxt.z = {cur.z[mclsc_pkg::Z_W-2:0], fb_z};
		end
	end

	assign ks = nxt.x[mclsc_pkg::X_W-1] ^ nxt.y[mclsc_pkg::Y_W-1] ^ nxt.z[mclsc_pkg::Z_W-1];

endmodule

/* sv/majority_clocked_lfsr_stream_cipher.sv */
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Beat when
// --------  ---------  ----------------------------------------  -------------------
// text      in         text_bit                                  valid && ready
// result    out        out_bit, keystream_bit, last_in_block     valid && ready
// key_cfg   in         cipher_key (64 bits)                      valid && ready
//
// One text beat per cycle is sustained while the result side keeps taking beats. From an
// accepted text beat to its result beat, the bit passes the input register, then
// the result register. The single majority-clocked step of the three LFSRs
// between them sets the cycle, and that step is the loop carried from bit to bit.
// Reset clears the key, the LFSRs, the block position and both valid flags.
// A stalled result holds; the input register still accepts while the result
// register drains in the same cycle, so stalls on the result side back up one
// beat at a time.
module majority_clocked_lfsr_stream_cipher #(
	parameter int unsigned BLOCK_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	mclsc_text_if.sink      text,
	mclsc_result_if.source  result,
	mclsc_key_if.sink       key_cfg
);

	// The block position counter needs at least one bit, even for one-bit blocks.
	localparam int unsigned POS_W = (BLOCK_BITS > 1) ? $clog2(BLOCK_BITS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BITS - 1);

	logic [mclsc_pkg::KEY_W-1:0] key_q;

	// Input register.
	logic s1_valid_q;
	logic text_s1;

	// LFSR state and the position of the next bit within its block.
	mclsc_pkg::lfsr_state_t state_q;
	mclsc_pkg::lfsr_state_t state_cur;
	mclsc_pkg::lfsr_state_t state_nxt;
	logic [POS_W-1:0]       pos_q;
	logic                   ks;
	logic                   last;

	// Result register.
	logic s2_valid_q;
	logic out_bit_s2;
	logic ks_s2;
	logic last_s2;

	logic s2_free;
	logic s1_move;
	logic text_beat;

	// The key register is always ready; a new key only matters at the next
	// block start.
	assign key_cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_cfg.valid) begin
			key_q <= key_cfg.cipher_key;
		end
	end

	// Handshake: the result register frees when it is empty or being taken,
	// and the input register advances into it whenever that happens.
	assign s2_free    = !s2_valid_q || result.ready;
	assign s1_move    = s1_valid_q && s2_free;
	assign text.ready = !s1_valid_q || s2_free;
	assign text_beat  = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (text.ready) begin
			s1_valid_q <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_beat) begin
			text_s1 <= text.text_bit;
		end
	end

	// The first bit of every block starts from a fresh fill of the key.
	always_comb begin
		state_cur = state_q;
		if (pos_q == '0) begin
			state_cur.x = key_q[mclsc_pkg::X_KEY_LO +: mclsc_pkg::X_W];
			state_cur.y = key_q[mclsc_pkg::Y_KEY_LO +: mclsc_pkg::Y_W];
			state_cur.z = key_q[mclsc_pkg::Z_KEY_LO +: mclsc_pkg::Z_W];
		end
	end

	mclsc_step u_step (
		.cur (state_cur),
		.nxt (state_nxt),
		.ks  (ks)
	);

	assign last = (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			pos_q   <= '0;
		end else if (s1_move) begin
			state_q <= state_nxt;
			pos_q   <= last ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_bit_s2 <= text_s1 ^ ks;
			ks_s2      <= ks;
			last_s2    <= last;
		end
	end

	assign result.valid         = s2_valid_q;
	assign result.out_bit       = out_bit_s2;
	assign result.keystream_bit = ks_s2;
	assign result.last_in_block = last_s2;

`ifndef SYNTHESIS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < int'(BLOCK_BITS))
		else $error("block position ran past the block length");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && last |=> pos_q == '0)
		else $error("block position did not wrap after the last bit");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(state_q) && $stable(pos_q))
		else $error("LFSR state changed without a bit being processed");

	a_move_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> s2_valid_q)
		else $error("processed bit did not reach the result register");

	a_output_matches_ks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_bit_s2 == ($past(text_s1) ^ ks_s2))
		else $error("result bit is not text XOR keystream");
`endif

endmodule

/* tb/majority_clocked_lfsr_stream_cipher_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the majority-clocked LFSR stream cipher.
// Text bits go in one beat at a time. A behavioral model of the three LFSRs
// runs alongside and queues the expected result for every accepted text beat.
// A checker pops the queue on every result beat. Key writes happen only while
// the pipeline is empty, so the model can take the new key at the write beat.
module majority_clocked_lfsr_stream_cipher_tb;

	localparam int unsigned BLOCK_BITS  = 64;
	localparam int unsigned ITEM_TARGET = 1250;
	// This limit leaves a wide margin over the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// The DUT holds a text beat in its input and result registers; these idle cycles cover its pipeline.
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned MAX_REPORTS  = 40;

	typedef struct packed {
		logic out_bit;
		logic keystream_bit;
		logic last_in_block;
	} cipher_beat_t;

	// These are the ways the result side applies back-pressure.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;

	mclsc_text_if   text_ch();
	mclsc_result_if result_ch();
	mclsc_key_if    key_ch();

	majority_clocked_lfsr_stream_cipher #(
		.BLOCK_BITS(BLOCK_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.result(result_ch),
		.key_cfg(key_ch)
	);

	// The model state mirrors the key register, the three LFSRs and the position in the block.
	logic [mclsc_pkg::KEY_W-1:0] key_shadow = '0;
	mclsc_pkg::lfsr_state_t      lfsr_model = '0;
	int unsigned                 block_pos  = 0;

	cipher_beat_t expected_beats[$];
	int unsigned  error_count = 0;
	int unsigned  items_sent  = 0;
	int unsigned  cycle_count = 0;

	// These are the sender burst controls. When sender_bursty is low, valid stays up back to back.
	logic sender_bursty = 1'b0;
	int   burst_left    = 0;

	rx_mode_t    rx_mode = RX_ALWAYS;
	int unsigned rx_hold = 0;
	int unsigned rx_tick = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the model by one text bit and return the beat the DUT should produce.
	// The LFSRs are refilled from the key at the first bit of each block. Then every
	// register whose clock bit agrees with the majority shifts up and takes its
	// feedback into bit 0.
	function automatic cipher_beat_t predict_beat(input logic text_in);
		logic         cx;
		logic         cy;
		logic         cz;
		logic         vote;
		cipher_beat_t beat;
		if (block_pos == 0) begin
			lfsr_model.x = key_shadow[mclsc_pkg::X_KEY_LO +: mclsc_pkg::X_W];
			lfsr_model.y = key_shadow[mclsc_pkg::Y_KEY_LO +: mclsc_pkg::Y_W];
			lfsr_model.z = key_shadow[mclsc_pkg::Z_KEY_LO +: mclsc_pkg::Z_W];
		end
		cx   = lfsr_model.x[mclsc_pkg::X_CLK];
		cy   = lfsr_model.y[mclsc_pkg::Y_CLK];
		cz   = lfsr_model.z[mclsc_pkg::Z_CLK];
		vote = (cx & cy) | (cx & cz) | (cy & cz);
		if (cx == vote) begin
			lfsr_model.x = {lfsr_model.x[mclsc_pkg::X_W-2:0],
				lfsr_model.x[mclsc_pkg::X_TAP_A] ^ lfsr_model.x[mclsc_pkg::X_TAP_B]
				^ lfsr_model.x[mclsc_pkg::X_TAP_C] ^ lfsr_model.x[mclsc_pkg::X_TAP_D]};
		end
		if (cy == vote) begin
			lfsr_model.y = {lfsr_model.y[mclsc_pkg::Y_W-2:0],
				lfsr_model.y[mclsc_pkg::Y_TAP_A] ^ lfsr_model.y[mclsc_pkg::Y_TAP_B]};
		end
		if (cz == vote) begin
			lfsr_model.z = {lfsr_model.z[mclsc_pkg::Z_W-2:0],
				lfsr_model.z[mclsc_pkg::Z_TAP_A] ^ lfsr_model.z[mclsc_pkg::Z_TAP_B]
				^ lfsr_model.z[mclsc_pkg::Z_TAP_C] ^ lfsr_model.z[mclsc_pkg::Z_TAP_D]};
		end
		beat.keystream_bit = lfsr_model.x[mclsc_pkg::X_W-1] ^ lfsr_model.y[mclsc_pkg::Y_W-1]
			^ lfsr_model.z[mclsc_pkg::Z_W-1];
		beat.out_bit       = text_in ^ beat.keystream_bit;
		beat.last_in_block = (block_pos + 1 >= BLOCK_BITS);
		block_pos          = beat.last_in_block ? 0 : block_pos + 1;
		return beat;
	endfunction

	// Present one text bit and hold it until the DUT takes it. The expectation is
	// queued at the accepting edge. The result passes the input and result registers first.
	// When a burst runs out, valid may drop for a random gap, and the data lines carry
	// junk during the gap.
	task automatic send_text_bit(input logic text_in);
		int gap;
		text_ch.valid    <= 1'b1;
		text_ch.text_bit <= text_in;
		@(posedge clk);
		while (!text_ch.ready) begin
			@(posedge clk);
		end
		expected_beats.push_back(predict_beat(text_in));
		items_sent++;
		burst_left--;
		if (sender_bursty && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 9);
			if (gap > 0) begin
				text_ch.valid    <= 1'b0;
				text_ch.text_bit <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_bits(input int unsigned count);
		repeat (count) send_text_bit(1'($urandom_range(0, 1)));
	endtask

	// Drop the text valid and let every outstanding result come back. Then wait out
	// the pipeline so the DUT is truly idle before a key write.
	task automatic drain_pipeline();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the key register once the pipeline is empty. The model picks up the new
	// key at the same beat. Like the DUT, it uses the key only at the next block start.
	task automatic load_cipher_key(input logic [mclsc_pkg::KEY_W-1:0] key_value);
		drain_pipeline();
		key_ch.valid      <= 1'b1;
		key_ch.cipher_key <= key_value;
		@(posedge clk);
		while (!key_ch.ready) begin
			@(posedge clk);
		end
		key_ch.valid <= 1'b0;
		key_shadow = key_value;
	endtask

	// After reset the key and all LFSRs are zero. The all-zero state is a fixed
	// point, so the keystream stays zero and the text must pass straight through.
	task automatic test_reset_state();
		sender_bursty = 1'b0;
		send_text_bit(1'b0);
		send_text_bit(1'b1);
		send_text_bit(1'b1);
		send_text_bit(1'b0);
		send_text_bit(1'b1);
		send_text_bit(1'b0);
		send_text_bit(1'b0);
		send_text_bit(1'b1);
	endtask

	// A key written in the middle of a block must not disturb the running LFSRs.
	// With the zero fill still in place, the stream stays zero until the block ends.
	task automatic test_key_write_mid_block();
		load_cipher_key({mclsc_pkg::KEY_W{1'b1}});
		sender_bursty = 1'b1;
		send_random_bits(12);
	endtask

	// Run through a range of extreme keys. Some keys fill one register alone or set every
	// bit or no bit; others alternate bits, set or clear one random bit, or are random. Each
	// phase sends 40 to 140 bits, and each write lands wherever the previous phase stopped.
	task automatic test_key_extremes();
		logic [mclsc_pkg::KEY_W-1:0] key_list[10];
		key_list[0] = '0;
		key_list[1] = {mclsc_pkg::KEY_W{1'b1}};
		key_list[2] = {(mclsc_pkg::KEY_W/2){2'b01}};
		key_list[3] = {(mclsc_pkg::KEY_W/2){2'b10}};
		key_list[4] = ((64'd1 << mclsc_pkg::X_W) - 1) << mclsc_pkg::X_KEY_LO;
		key_list[5] = ((64'd1 << mclsc_pkg::Y_W) - 1) << mclsc_pkg::Y_KEY_LO;
		key_list[6] = ((64'd1 << mclsc_pkg::Z_W) - 1) << mclsc_pkg::Z_KEY_LO;
		key_list[7] = 64'd1 << $urandom_range(0, mclsc_pkg::KEY_W - 1);
		key_list[8] = ~(64'd1 << $urandom_range(0, mclsc_pkg::KEY_W - 1));
		key_list[9] = {$urandom, $urandom};
		foreach (key_list[i]) begin
			load_cipher_key(key_list[i]);
			sender_bursty = ($urandom_range(0, 3) != 0);
			send_random_bits($urandom_range(40, 140));
		end
	endtask

	// Random keys with random stream lengths until the item budget is spent. Now and
	// then the stream runs back to back without gaps.
	task automatic test_random_traffic();
		while (items_sent < ITEM_TARGET) begin
			load_cipher_key({$urandom, $urandom});
			sender_bursty = ($urandom_range(0, 3) != 0);
			send_random_bits($urandom_range(20, 150));
		end
	endtask

	// The result side's ready follows a mode that changes at random intervals.
	// Some modes never stall, some stall at random, some stall on a
	// fixed rhythm, and some let a beat through only rarely.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_hold <= $urandom_range(20, 240);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_mode)
			RX_ALWAYS: begin
				result_ch.ready <= 1'b1;
			end
			RX_RANDOM: begin
				result_ch.ready <= 1'($urandom_range(0, 1));
			end
			RX_PERIODIC: begin
				result_ch.ready <= (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
			end
			default: begin
				result_ch.ready <= ($urandom_range(0, 5) == 0);
			end
		endcase
	end

	// Every result beat must match the oldest expectation field by field. A beat that
	// arrives with nothing waiting is an error as well.
	always @(posedge clk) begin : check_results
		cipher_beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("%0t: unexpected result beat, expected none, actual out=%b ks=%b last=%b",
						$time, result_ch.out_bit, result_ch.keystream_bit,
						result_ch.last_in_block);
				end
			end else begin
				want = expected_beats.pop_front();
				if (result_ch.out_bit !== want.out_bit) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: out_bit mismatch, expected %b actual %b",
							$time, want.out_bit, result_ch.out_bit);
					end
				end
				if (result_ch.keystream_bit !== want.keystream_bit) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: keystream_bit mismatch, expected %b actual %b",
							$time, want.keystream_bit, result_ch.keystream_bit);
					end
				end
				if (result_ch.last_in_block !== want.last_in_block) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: last_in_block mismatch, expected %b actual %b",
							$time, want.last_in_block, result_ch.last_in_block);
					end
				end
			end
		end
	end

	// This watchdog stops a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("majority_clocked_lfsr_stream_cipher verification failed");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		text_ch.valid     = 1'b0;
		text_ch.text_bit  = 1'b0;
		result_ch.ready   = 1'b0;
		key_ch.valid      = 1'b0;
		key_ch.cipher_key = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_key_write_mid_block();
		test_key_extremes();
		test_random_traffic();

		// Wait for the last results, then wait out the pipeline so a
		// stray beat would still be caught.
		drain_pipeline();
		if (error_count == 0 && expected_beats.size() == 0) begin
			$display("majority_clocked_lfsr_stream_cipher verification clean");
		end else begin
			$display("majority_clocked_lfsr_stream_cipher verification failed");
		end
		$finish;
	end

endmodule
